@@ rtl/core/fractional_box_decimator_top_assert.svh @@
// Assertion macros for the fractional box decimator.
`ifndef FRACTIONAL_BOX_DECIMATOR_TOP_ASSERT_SVH
`define FRACTIONAL_BOX_DECIMATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk, off during reset.
`define FBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define FBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fbd_pkg.sv @@
// Shared constants, types and the boundary step for the box decimator.
package fbd_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int RATE_BITS      = 19;
    localparam int LEN_BITS       = 16;
    localparam int SUM_BITS       = 32;
    localparam int COUNT_BITS     = 19;
    localparam int POS_BITS       = 32;
    localparam int REM_BITS       = RATE_BITS + 1;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = RATE_BITS;
    localparam int RATE_CNT_BITS  = $clog2(RATE_BITS);
    localparam int QUO_CNT_BITS   = $clog2(SAMPLE_BITS);
    localparam int Q_DEPTH        = 4;
    localparam int Q_PTR_BITS     = $clog2(Q_DEPTH);

    localparam logic [CFG_INDEX_BITS-1:0] REG_IN_RATE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_RATE   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_LENGTH = 2'd2;

    localparam logic [RATE_BITS-1:0] IN_RATE_RESET    = 19'd48000;
    localparam logic [RATE_BITS-1:0] OUT_RATE_RESET   = 19'd16000;
    localparam logic [LEN_BITS-1:0]  OUT_LENGTH_RESET = 16'd65535;

    // closed window handed from front to back
    typedef struct packed {
        logic [SUM_BITS-1:0]   sum;
        logic [COUNT_BITS-1:0] count;
        logic                  last;
    } win_t;

    typedef struct packed {
        logic                carry;
        logic [REM_BITS-1:0] rem;
    } step_t;

    // One boundary advance: rem + r0 against den, r0 and rem both below den.
    function automatic step_t bound_step(input logic [REM_BITS-1:0] rem,
                                         input logic [REM_BITS-1:0] r0,
                                         input logic [REM_BITS-1:0] den);
        logic [REM_BITS:0] acc;
        step_t             res;
        acc       = {1'b0, rem} + {1'b0, r0};
        res.carry = (acc >= {1'b0, den});
        res.rem   = res.carry ? REM_BITS'(acc - {1'b0, den}) : acc[REM_BITS-1:0];
        return res;
    endfunction

endpackage

@@ rtl/core/fbd_front.sv @@
// Front end: registers, ratio divide, window accumulation and boundary tracking.
module fbd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [fbd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [fbd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                push,
    input  logic signed [fbd_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                buffer_end,
    output logic                                full,
    input  logic                                q_full,
    output logic                                q_push,
    output fbd_pkg::win_t                       q_word
);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_INIT = 2'd2;

    logic [1:0]                          state_reg, state_next;
    logic [fbd_pkg::RATE_BITS-1:0]       in_rate_reg, in_rate_next;
    logic [fbd_pkg::RATE_BITS-1:0]       out_rate_reg, out_rate_next;
    logic [fbd_pkg::LEN_BITS-1:0]        out_length_reg, out_length_next;
    logic [fbd_pkg::RATE_CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [fbd_pkg::RATE_BITS-1:0]       dq_reg, dq_next;
    logic [fbd_pkg::RATE_BITS-1:0]       dr_reg, dr_next;
    logic [fbd_pkg::RATE_BITS-1:0]       ratio_q_reg, ratio_q_next;
    logic [fbd_pkg::REM_BITS-1:0]        ratio_r0_reg, ratio_r0_next;
    logic [fbd_pkg::SUM_BITS-1:0]        sum_reg, sum_next;
    logic [fbd_pkg::COUNT_BITS-1:0]      count_reg, count_next;
    logic [fbd_pkg::POS_BITS-1:0]        pos_reg, pos_next;
    logic [fbd_pkg::LEN_BITS-1:0]        done_reg, done_next;
    logic [fbd_pkg::POS_BITS-1:0]        wend_reg, wend_next;
    logic [fbd_pkg::REM_BITS-1:0]        erem_reg, erem_next;

    logic                                decim;
    logic [fbd_pkg::REM_BITS-1:0]        den;
    logic                                accept;
    logic                                active;
    logic                                cfg_hit;
    logic [fbd_pkg::REM_BITS-1:0]        dr_shift;
    logic                                dr_ge;
    fbd_pkg::step_t                      fst;
    fbd_pkg::step_t                      nxt;
    logic [fbd_pkg::POS_BITS-1:0]        wend_first;
    logic [fbd_pkg::REM_BITS-1:0]        erem_first;
    logic signed [fbd_pkg::SUM_BITS:0]   s_wide;
    logic [fbd_pkg::SUM_BITS-1:0]        s_sat;
    logic [fbd_pkg::COUNT_BITS-1:0]      count_inc;
    logic [fbd_pkg::POS_BITS-1:0]        pos_inc;
    logic [fbd_pkg::LEN_BITS-1:0]        done_inc;
    logic                                close;

    assign decim   = (out_rate_reg != '0) && (in_rate_reg > out_rate_reg);
    assign den     = {out_rate_reg, 1'b0};
    assign full    = (state_reg != ST_RUN) || q_full;
    assign accept  = push && !full;
    assign active  = decim && (done_reg < out_length_reg);
    assign cfg_hit = cfg_write && ((cfg_index == fbd_pkg::REG_IN_RATE) ||
                     (cfg_index == fbd_pkg::REG_OUT_RATE) ||
                     (cfg_index == fbd_pkg::REG_OUT_LENGTH));

    // restoring divide in_rate / out_rate, one quotient bit a cycle
    assign dr_shift = {dr_reg, dq_reg[fbd_pkg::RATE_BITS-1]};
    assign dr_ge    = (dr_shift >= {1'b0, out_rate_reg});

    // 2*in/(2*out) = Q rem 2*R, so each boundary is Q plus a carry
    assign fst        = fbd_pkg::bound_step({1'b0, out_rate_reg}, ratio_r0_reg, den);
    assign nxt        = fbd_pkg::bound_step(erem_reg, ratio_r0_reg, den);
    assign wend_first = decim ? (fbd_pkg::POS_BITS'(ratio_q_reg) +
                                 fbd_pkg::POS_BITS'(fst.carry)) : '0;
    assign erem_first = decim ? fst.rem : {1'b0, out_rate_reg};

    assign s_wide    = (fbd_pkg::SUM_BITS+1)'(signed'(sum_reg)) +
                       (fbd_pkg::SUM_BITS+1)'(sample_in);
    // one bit of headroom: saturate when the top two bits disagree
    assign s_sat     = (s_wide[fbd_pkg::SUM_BITS] != s_wide[fbd_pkg::SUM_BITS-1]) ?
                       (s_wide[fbd_pkg::SUM_BITS] ? {1'b1, {(fbd_pkg::SUM_BITS-1){1'b0}}}
                                                  : {1'b0, {(fbd_pkg::SUM_BITS-1){1'b1}}})
                       : s_wide[fbd_pkg::SUM_BITS-1:0];
    assign count_inc = count_reg + 1'b1;
    assign pos_inc   = pos_reg + 1'b1;
    assign done_inc  = done_reg + 1'b1;
    assign close     = (pos_inc == wend_reg) || buffer_end;

    assign q_push      = accept && active && close;
    assign q_word.sum   = s_sat;
    assign q_word.count = count_inc;
    assign q_word.last  = buffer_end || (done_inc >= out_length_reg);

    always_comb
    begin
        state_next      = state_reg;
        in_rate_next    = in_rate_reg;
        out_rate_next   = out_rate_reg;
        out_length_next = out_length_reg;
        cnt_next        = cnt_reg;
        dq_next         = dq_reg;
        dr_next         = dr_reg;
        ratio_q_next    = ratio_q_reg;
        ratio_r0_next   = ratio_r0_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        done_next       = done_reg;
        wend_next       = wend_reg;
        erem_next       = erem_reg;

        if (cfg_hit)
        begin
            unique case (cfg_index)
                fbd_pkg::REG_IN_RATE:  in_rate_next  = cfg_data;
                fbd_pkg::REG_OUT_RATE: out_rate_next = cfg_data;
                default:               out_length_next = fbd_pkg::LEN_BITS'(cfg_data);
            endcase
            state_next = ST_DIV;
            cnt_next   = '0;
            dq_next    = (cfg_index == fbd_pkg::REG_IN_RATE) ? cfg_data : in_rate_reg;
            dr_next    = '0;
            sum_next   = '0;
            count_next = '0;
            pos_next   = '0;
            done_next  = '0;
        end
        else
        begin
            unique case (state_reg)
                ST_DIV:
                begin
                    dq_next = {dq_reg[fbd_pkg::RATE_BITS-2:0], dr_ge};
                    dr_next = dr_ge ? fbd_pkg::RATE_BITS'(dr_shift - {1'b0, out_rate_reg})
                                    : dr_shift[fbd_pkg::RATE_BITS-1:0];
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == fbd_pkg::RATE_CNT_BITS'(fbd_pkg::RATE_BITS - 1))
                    begin
                        ratio_q_next  = {dq_reg[fbd_pkg::RATE_BITS-2:0], dr_ge};
                        ratio_r0_next = {dr_next, 1'b0};
                        state_next    = ST_INIT;
                    end
                end
                ST_INIT:
                begin
                    wend_next  = wend_first;
                    erem_next  = erem_first;
                    state_next = ST_RUN;
                end
                default:
                begin
                    if (accept)
                    begin
                        if (active)
                        begin
                            sum_next   = s_sat;
                            count_next = count_inc;
                            pos_next   = pos_inc;
                            if (close)
                            begin
                                done_next  = done_inc;
                                sum_next   = '0;
                                count_next = '0;
                                wend_next  = wend_reg + fbd_pkg::POS_BITS'(ratio_q_reg) +
                                             fbd_pkg::POS_BITS'(nxt.carry);
                                erem_next  = nxt.rem;
                            end
                        end
                        if (buffer_end)
                        begin
                            sum_next   = '0;
                            count_next = '0;
                            pos_next   = '0;
                            done_next  = '0;
                            wend_next  = wend_first;
                            erem_next  = erem_first;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_DIV;
            in_rate_reg    <= fbd_pkg::IN_RATE_RESET;
            out_rate_reg   <= fbd_pkg::OUT_RATE_RESET;
            out_length_reg <= fbd_pkg::OUT_LENGTH_RESET;
            cnt_reg        <= '0;
            dq_reg         <= fbd_pkg::IN_RATE_RESET;
            dr_reg         <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            pos_reg        <= '0;
            done_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            in_rate_reg    <= in_rate_next;
            out_rate_reg   <= out_rate_next;
            out_length_reg <= out_length_next;
            cnt_reg        <= cnt_next;
            dq_reg         <= dq_next;
            dr_reg         <= dr_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            done_reg       <= done_next;
        end
    end

    // loaded in setup before any sample is taken; wend/erem also advance in run
    always_ff @(posedge clk)
    begin
        ratio_q_reg  <= ratio_q_next;
        ratio_r0_reg <= ratio_r0_next;
        wend_reg     <= wend_next;
        erem_reg     <= erem_next;
    end

endmodule

@@ rtl/core/fbd_queue.sv @@
// Short queue of closed windows between front and back.
module fbd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fbd_pkg::win_t word_in,
    output logic          full,
    input  logic          pop,
    output fbd_pkg::win_t word_out,
    output logic          empty
);

    fbd_pkg::win_t                 mem_reg [fbd_pkg::Q_DEPTH];
    logic [fbd_pkg::Q_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fbd_pkg::Q_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fbd_pkg::Q_PTR_BITS:0]   fill_reg, fill_next;
    logic                           do_push;
    logic                           do_pop;

    assign full     = (fill_reg == (fbd_pkg::Q_PTR_BITS+1)'(fbd_pkg::Q_DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign word_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= word_in;
        end
    end

endmodule

@@ rtl/core/fbd_back.sv @@
// Back end: signed window average by iterative divide, and the result register.
module fbd_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_empty,
    input  fbd_pkg::win_t                          q_word,
    output logic                                   q_pop,
    input  logic                                   pop,
    output logic                                   empty,
    output logic signed [fbd_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic                                   last_out
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_DIV  = 2'd1;
    localparam logic [1:0] B_HOLD = 2'd2;

    logic [1:0]                          bstate_reg, bstate_next;
    logic [fbd_pkg::QUO_CNT_BITS-1:0]    bcnt_reg, bcnt_next;
    logic                                neg_reg, neg_next;
    logic                                last_reg, last_next;
    logic [fbd_pkg::COUNT_BITS-1:0]      div_reg, div_next;
    logic [fbd_pkg::COUNT_BITS-1:0]      rem_reg, rem_next;
    logic [fbd_pkg::SAMPLE_BITS-1:0]     lo_reg, lo_next;
    logic                                out_valid_reg, out_valid_next;
    logic [fbd_pkg::SAMPLE_BITS-1:0]     sample_out_reg, sample_out_next;
    logic                                last_out_reg, last_out_next;

    logic                                in_neg;
    logic [fbd_pkg::SUM_BITS-1:0]        mag;
    logic [fbd_pkg::SUM_BITS-1:0]        mag_hi;
    logic [fbd_pkg::COUNT_BITS:0]        sh;
    logic                                ge;
    logic [fbd_pkg::SAMPLE_BITS-1:0]     res;
    logic                                xfer;

    assign in_neg = q_word.sum[fbd_pkg::SUM_BITS-1];
    assign mag    = in_neg ? (~q_word.sum + 1'b1) : q_word.sum;
    // quotient fits in SAMPLE_BITS, so the upper part is already below the count
    assign mag_hi = mag >> fbd_pkg::SAMPLE_BITS;

    assign sh  = {rem_reg, lo_reg[fbd_pkg::SAMPLE_BITS-1]};
    assign ge  = (sh >= {1'b0, div_reg});
    assign res = neg_reg ? (~lo_reg + 1'b1) : lo_reg;

    assign q_pop = (bstate_reg == B_IDLE) && !q_empty;
    assign xfer  = (bstate_reg == B_HOLD) && (!out_valid_reg || pop);

    assign empty      = !out_valid_reg;
    assign sample_out = signed'(sample_out_reg);
    assign last_out   = last_out_reg;

    always_comb
    begin
        bstate_next     = bstate_reg;
        bcnt_next       = bcnt_reg;
        neg_next        = neg_reg;
        last_next       = last_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        lo_next         = lo_reg;
        sample_out_next = sample_out_reg;
        last_out_next   = last_out_reg;
        out_valid_next  = out_valid_reg && !pop;

        unique case (bstate_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    neg_next    = in_neg;
                    last_next   = q_word.last;
                    div_next    = q_word.count;
                    rem_next    = mag_hi[fbd_pkg::COUNT_BITS-1:0];
                    lo_next     = mag[fbd_pkg::SAMPLE_BITS-1:0];
                    bcnt_next   = '0;
                    bstate_next = B_DIV;
                end
            end
            B_DIV:
            begin
                rem_next  = ge ? fbd_pkg::COUNT_BITS'(sh - {1'b0, div_reg})
                               : sh[fbd_pkg::COUNT_BITS-1:0];
                lo_next   = {lo_reg[fbd_pkg::SAMPLE_BITS-2:0], ge};
                bcnt_next = bcnt_reg + 1'b1;
                if (bcnt_reg == fbd_pkg::QUO_CNT_BITS'(fbd_pkg::SAMPLE_BITS - 1))
                begin
                    bstate_next = B_HOLD;
                end
            end
            default:
            begin
                if (xfer)
                begin
                    sample_out_next = res;
                    last_out_next   = last_reg;
                    out_valid_next  = 1'b1;
                    bstate_next     = B_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstate_reg    <= B_IDLE;
            bcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bstate_reg    <= bstate_next;
            bcnt_reg      <= bcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg        <= neg_next;
        last_reg       <= last_next;
        div_reg        <= div_next;
        rem_reg        <= rem_next;
        lo_reg         <= lo_next;
        sample_out_reg <= sample_out_next;
        last_out_reg   <= last_out_next;
    end

endmodule

@@ rtl/core/fractional_box_decimator_top.sv @@
// Top level of the fractional-ratio boxcar decimator.
//
//  channel  | handshake          | word
//  ---------+--------------------+------------------------------------
//  input    | push / full        | sample_in, buffer_end
//  result   | pop / empty        | sample_out, last_out
//  config   | cfg_write          | cfg_index, cfg_data
//
// The front takes one sample a cycle while full is low; boundaries advance by
// add and compare. The back averages each closed window one quotient bit a
// cycle, after a load and before the hand-off; a 4-deep window queue sits
// between them. After reset and after every register write, full stays high
// while the in_rate/out_rate ratio is divided out, one bit a cycle.
// full also rises when the window queue is full; a waiting result never
// blocks the front until that queue fills.
module fractional_box_decimator_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [fbd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [fbd_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [fbd_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                   buffer_end,
    input  logic                                   pop,
    output logic                                   empty,
    output logic signed [fbd_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic                                   last_out
);

    `include "fractional_box_decimator_top_assert.svh"

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    fbd_pkg::win_t q_in_word;
    fbd_pkg::win_t q_out_word;
    logic          cfg_hit;

    assign cfg_hit = cfg_write && ((cfg_index == fbd_pkg::REG_IN_RATE) ||
                     (cfg_index == fbd_pkg::REG_OUT_RATE) ||
                     (cfg_index == fbd_pkg::REG_OUT_LENGTH));

    fbd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .sample_in  (sample_in),
        .buffer_end (buffer_end),
        .full       (full),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_word     (q_in_word)
    );

    fbd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .word_in  (q_in_word),
        .full     (q_full),
        .pop      (q_pop),
        .word_out (q_out_word),
        .empty    (q_empty)
    );

    fbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_word     (q_out_word),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .sample_out (sample_out),
        .last_out   (last_out)
    );

    `FBD_ASSERT_NOW(a_no_push_when_full, q_push, !q_full, "window pushed into full queue")
    `FBD_ASSERT_NOW(a_no_pop_when_empty, q_pop, !q_empty, "window popped from empty queue")
    `FBD_ASSERT_NEXT(a_cfg_blocks_input, cfg_hit, full, "input open during ratio setup")

endmodule
